// ----- src/rtpd_pkg.sv -----
// Shared types, widths and per-bit step functions for the range to planar depth converter.
package rtpd_pkg;

    localparam int IMG_WIDTH_DEF  = 640;
    localparam int IMG_HEIGHT_DEF = 480;

    localparam int RANGE_W = 32;
    localparam int ROW_W   = 9;
    localparam int COL_W   = 10;
    localparam int CFG_W   = 16;
    localparam int DEPTH_W = 16;
    localparam int CIDX_W  = 1;

    // half-pixel offsets from the image center
    localparam int OFF_W  = 14;
    localparam int AOFF_W = 13;

    localparam int MAG_W  = 32;
    localparam int P1_W   = 48;
    localparam int PROD_W = 64;
    localparam int SQ_W   = 32;
    localparam int D2_W   = 34;
    localparam int V_W    = D2_W + 16;
    localparam int S_W    = V_W / 2;
    localparam int DEN_W  = S_W + 8;
    localparam int Q_W    = DEPTH_W;
    localparam int REM_W  = DEN_W + Q_W;

    localparam logic [CIDX_W-1:0] CFG_DEPTH_SCALE = 1'd0;
    localparam logic [CIDX_W-1:0] CFG_FOCAL       = 1'd1;

    localparam logic [CFG_W-1:0] DEPTH_SCALE_RST = 16'd50;
    localparam logic [CFG_W-1:0] FOCAL_RST       = 16'd7690;

    typedef struct packed {
        logic [V_W-1:0]    rem;
        logic [S_W-1:0]    root;
        logic [PROD_W-1:0] prod;
        logic              neg;
    } sq_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   quo;
        logic             neg;
        logic             zero;
        logic             ovf;
    } dv_t;

    // one result bit of the integer square root
    function automatic sq_t sqrt_step(sq_t s, int i);
        logic [V_W:0] t;
        sq_t          r;
        t = ((V_W+1)'(s.root) << (i + 1)) + ((V_W+1)'(1) << (2 * i));
        r = s;
        if ({1'b0, s.rem} >= t)
        begin
            r.rem  = s.rem - V_W'(t);
            r.root = s.root | (S_W'(1) << i);
        end
        return r;
    endfunction

    // one quotient bit of the restoring divide
    function automatic dv_t div_step(dv_t d, int i);
        logic [REM_W-1:0] sh;
        dv_t              r;
        sh = REM_W'(d.den) << i;
        r  = d;
        if (d.rem >= sh)
        begin
            r.rem = d.rem - sh;
            r.quo = d.quo | (Q_W'(1) << i);
        end
        return r;
    endfunction

endpackage

// ----- src/range_to_planar_depth.sv -----
// Range to planar depth converter: top level with the full arithmetic pipeline.
// Converts a radial range sample into depth along the optical axis at one beat per clock
// while range_stall is low. An accepted input beat passes to its output beat through
// 3 front stages (abs/offsets, multiplies, product and norm sum), one stage per
// bit of the 25-bit square root, one divide setup stage, one stage per bit of the 16-bit
// quotient and the output register. The whole pipeline advances together; a two-entry output
// buffer (output register plus skid) lets the next beat be taken while a result waits, and
// range_stall is simply that skid entry being full. Configuration writes are always ready and
// must only happen while no beat is in flight.
module range_to_planar_depth
    import rtpd_pkg::*;
#(
    parameter int IMG_WIDTH  = IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = IMG_HEIGHT_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CIDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,

    input  logic                      range_valid,
    output logic                      range_stall,
    input  logic signed [RANGE_W-1:0] range_q16,
    input  logic [ROW_W-1:0]          pixel_row,
    input  logic [COL_W-1:0]          pixel_col,

    output logic                      depth_valid,
    input  logic                      depth_stall,
    output logic [DEPTH_W-1:0]        depth_value,
    output logic                      clamped
);

    localparam int NSQ = S_W;
    localparam int NDV = Q_W;

    logic [CFG_W-1:0] scale_reg;
    logic [CFG_W-1:0] focal_reg;

    logic adv;
    logic skid_v_reg;
    logic out_v_reg;
    logic out_take;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= DEPTH_SCALE_RST;
            focal_reg <= FOCAL_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DEPTH_SCALE: scale_reg <= cfg_data;
                CFG_FOCAL:       focal_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign adv         = !skid_v_reg;
    assign range_stall = skid_v_reg;

    // ---------------- stage A: magnitude and offsets ----------------
    logic                     a_v_reg;
    logic                     a_neg_reg;
    logic [MAG_W-1:0]         a_mag_reg;
    logic [AOFF_W-1:0]        a_ay_reg;
    logic [AOFF_W-1:0]        a_ax_reg;
    logic signed [OFF_W-1:0]  ry;
    logic signed [OFF_W-1:0]  rx;
    logic [OFF_W-1:0]         ry_abs;
    logic [OFF_W-1:0]         rx_abs;

    always_comb
    begin
        ry     = $signed({4'b0, pixel_row, 1'b0}) - $signed(OFF_W'(IMG_HEIGHT - 1));
        rx     = $signed({3'b0, pixel_col, 1'b0}) - $signed(OFF_W'(IMG_WIDTH - 1));
        ry_abs = ry[OFF_W-1] ? OFF_W'(-ry) : OFF_W'(ry);
        rx_abs = rx[OFF_W-1] ? OFF_W'(-rx) : OFF_W'(rx);
    end

    // ---------------- stage B: multiplies ----------------
    logic              b_v_reg;
    logic              b_neg_reg;
    logic [P1_W-1:0]   b_p1_reg;
    logic [SQ_W-1:0]   b_ff_reg;
    logic [SQ_W-1:0]   b_yy_reg;
    logic [SQ_W-1:0]   b_xx_reg;
    logic [2*AOFF_W-1:0] sqy;
    logic [2*AOFF_W-1:0] sqx;

    // offsets are in half pixels; Q3 squared adds another factor of 64
    assign sqy = a_ay_reg * a_ay_reg;
    assign sqx = a_ax_reg * a_ax_reg;

    // ---------------- stage C: product and squared norm ----------------
    logic              c_v_reg;
    logic              c_neg_reg;
    logic [PROD_W-1:0] c_prod_reg;
    logic [D2_W-1:0]   c_d2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg <= range_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_neg_reg  <= range_q16[RANGE_W-1];
            a_mag_reg  <= range_q16[RANGE_W-1] ? MAG_W'(-range_q16) : MAG_W'(range_q16);
            a_ay_reg   <= ry_abs[AOFF_W-1:0];
            a_ax_reg   <= rx_abs[AOFF_W-1:0];

            b_neg_reg  <= a_neg_reg;
            b_p1_reg   <= P1_W'(a_mag_reg) * P1_W'(scale_reg);
            b_ff_reg   <= SQ_W'(focal_reg) * SQ_W'(focal_reg);
            b_yy_reg   <= {sqy, 6'b0};
            b_xx_reg   <= {sqx, 6'b0};

            c_neg_reg  <= b_neg_reg;
            c_prod_reg <= PROD_W'(b_p1_reg) * PROD_W'(focal_reg);
            c_d2_reg   <= D2_W'(b_ff_reg) + D2_W'(b_yy_reg) + D2_W'(b_xx_reg);
        end
    end

    // ---------------- square root, one bit per stage ----------------
    sq_t            sq_in;
    sq_t            sq_reg  [NSQ];
    sq_t            sq_next [NSQ];
    logic [NSQ-1:0] sq_v_reg;

    always_comb
    begin
        sq_in.rem  = {c_d2_reg, 16'b0};
        sq_in.root = '0;
        sq_in.prod = c_prod_reg;
        sq_in.neg  = c_neg_reg;
    end

    for (genvar k = 0; k < NSQ; k++)
    begin : g_sqrt
        if (k == 0)
        begin : g_first
            assign sq_next[k] = sqrt_step(sq_in, NSQ - 1 - k);
        end
        else
        begin : g_rest
            assign sq_next[k] = sqrt_step(sq_reg[k-1], NSQ - 1 - k);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg <= '0;
        else if (adv)
            sq_v_reg <= {sq_v_reg[NSQ-2:0], c_v_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            sq_reg <= sq_next;
    end

    // ---------------- divide setup: rounding bias and overflow ----------------
    dv_t               d_reg;
    logic              d_v_reg;
    dv_t               d_next;
    logic [PROD_W-1:0] numer;
    logic [DEN_W-1:0]  den;
    logic [S_W-1:0]    root_fin;

    always_comb
    begin
        root_fin    = sq_reg[NSQ-1].root;
        numer       = sq_reg[NSQ-1].prod + {root_fin, 7'b0};
        den         = {root_fin, 8'b0};
        d_next.den  = den;
        d_next.quo  = '0;
        d_next.neg  = sq_reg[NSQ-1].neg;
        d_next.zero = (sq_reg[NSQ-1].prod == '0) || (root_fin == '0);
        d_next.ovf  = numer >= PROD_W'({den, 16'b0});
        d_next.rem  = d_next.ovf ? '0 : numer[REM_W-1:0];
    end

    // ---------------- restoring divide, one quotient bit per stage ----------------
    dv_t            dv_reg  [NDV];
    dv_t            dv_next [NDV];
    logic [NDV-1:0] dv_v_reg;

    for (genvar k = 0; k < NDV; k++)
    begin : g_div
        if (k == 0)
        begin : g_first
            assign dv_next[k] = div_step(d_reg, NDV - 1 - k);
        end
        else
        begin : g_rest
            assign dv_next[k] = div_step(dv_reg[k-1], NDV - 1 - k);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg  <= 1'b0;
            dv_v_reg <= '0;
        end
        else if (adv)
        begin
            d_v_reg  <= sq_v_reg[NSQ-1];
            dv_v_reg <= {dv_v_reg[NDV-2:0], d_v_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg  <= d_next;
            dv_reg <= dv_next;
        end
    end

    // ---------------- result and output buffer ----------------
    dv_t                fin;
    logic               last_v;
    logic [DEPTH_W-1:0] res_depth;
    logic               res_clamp;

    logic [DEPTH_W-1:0] out_depth_reg;
    logic               out_clamp_reg;
    logic [DEPTH_W-1:0] skid_depth_reg;
    logic               skid_clamp_reg;

    always_comb
    begin
        fin    = dv_reg[NDV-1];
        last_v = dv_v_reg[NDV-1];
        if (fin.zero || fin.neg)
            res_depth = '0;
        else if (fin.ovf)
            res_depth = '1;
        else
            res_depth = fin.quo;
        res_clamp = !fin.zero && (fin.neg || fin.ovf);
    end

    assign out_take = out_v_reg && !depth_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (out_take)
                skid_v_reg <= 1'b0;
        end
        else if (last_v)
        begin
            if (!out_v_reg || out_take)
                out_v_reg <= 1'b1;
            else
                skid_v_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (out_take)
            begin
                out_depth_reg <= skid_depth_reg;
                out_clamp_reg <= skid_clamp_reg;
            end
        end
        else if (last_v)
        begin
            if (!out_v_reg || out_take)
            begin
                out_depth_reg <= res_depth;
                out_clamp_reg <= res_clamp;
            end
            else
            begin
                skid_depth_reg <= res_depth;
                skid_clamp_reg <= res_clamp;
            end
        end
    end

    assign depth_valid = out_v_reg;
    assign depth_value = out_depth_reg;
    assign clamped     = out_clamp_reg;

    // ---------------- assertions ----------------
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry held while output register empty");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_v_reg && depth_stall) |=> skid_v_reg)
        else $error("skid entry dropped while output stalled");

    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_clamp_reg && (out_depth_reg != '0)) |-> (out_depth_reg == '1))
        else $error("clamped result neither zero nor full scale");

    a_frozen_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |=> $stable(dv_v_reg) || $past(out_take))
        else $error("pipeline moved while skid entry full");

endmodule

// ----- tb/sv/tb_range_to_planar_depth.sv -----
// Testbench for range_to_planar_depth: directed table, then random beats checked by a predictor.
module tb_range_to_planar_depth;
    import rtpd_pkg::*;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CIDX_W-1:0]         cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic                      range_valid;
    logic                      range_stall;
    logic signed [RANGE_W-1:0] range_q16;
    logic [ROW_W-1:0]          pixel_row;
    logic [COL_W-1:0]          pixel_col;
    logic                      depth_valid;
    logic                      depth_stall;
    logic [DEPTH_W-1:0]        depth_value;
    logic                      clamped;

    range_to_planar_depth u_top (.*);

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               clamp;
    } depth_res_t;

    typedef struct {
        logic [RANGE_W-1:0] rng;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               known;
        depth_res_t         res;
    } dir_row_t;

    localparam int LATENCY   = 46;
    localparam int N_RANDOM  = 1050;

    logic [CFG_W-1:0] scale_reg;
    logic [CFG_W-1:0] focal_reg;
    depth_res_t       depth_q[$];
    int               err_cnt;
    bit               quiet;
    bit               hold_long;

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic depth_res_t planar_depth(logic [RANGE_W-1:0] rng,
                                                logic [ROW_W-1:0] row,
                                                logic [COL_W-1:0] col);
        logic        neg;
        logic [31:0] nrng;
        logic [63:0] mag;
        longint      qy;
        longint      qx;
        logic [63:0] d2;
        logic [63:0] s;
        logic [63:0] prod;
        logic [63:0] m;
        depth_res_t  r;
        neg  = rng[31];
        nrng = ~rng + 32'd1;
        mag  = {32'b0, neg ? nrng : rng};
        if (neg && mag == 0)
            mag = 64'd1 << 31;
        qy   = 8 * (2 * longint'(row) - (IMG_HEIGHT_DEF - 1));
        qx   = 8 * (2 * longint'(col) - (IMG_WIDTH_DEF - 1));
        d2   = 64'(focal_reg) * 64'(focal_reg) + 64'(qy * qy) + 64'(qx * qx);
        s    = int_sqrt(d2 << 16);
        prod = mag * 64'(scale_reg) * 64'(focal_reg);
        r    = '0;
        if (prod == 0 || s == 0)
            r = '0;
        else if (neg)
            r.clamp = 1'b1;
        else
        begin
            m = (prod + 128 * s) / (256 * s);
            if (m > 65535)
            begin
                r.depth = 16'hFFFF;
                r.clamp = 1'b1;
            end
            else
                r.depth = m[15:0];
        end
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("DONE: errors detected");
        $finish;
    end

    // output side: stall bursts, one long hold-off, checking
    initial
    begin
        int gap;
        depth_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                depth_stall <= 1'b1;
                repeat (200) @(negedge clk);
                hold_long = 1'b0;
                depth_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 5);
                depth_stall <= 1'b1;
                repeat (gap) @(negedge clk);
                depth_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        depth_res_t exp_r;
        if (rst_n && depth_valid && !depth_stall)
        begin
            if (depth_q.size() == 0)
            begin
                $error("unexpected depth beat: depth_value=%0d clamped=%0d",
                       depth_value, clamped);
                err_cnt++;
            end
            else
            begin
                exp_r = depth_q.pop_front();
                if (depth_value !== exp_r.depth)
                begin
                    $error("depth_value expected %0d actual %0d", exp_r.depth, depth_value);
                    err_cnt++;
                end
                if (clamped !== exp_r.clamp)
                begin
                    $error("clamped expected %0d actual %0d", exp_r.clamp, clamped);
                    err_cnt++;
                end
            end
        end
    end

    // valid stays up between beats; idle gaps and drain() drop it
    task automatic send_range(logic [RANGE_W-1:0] rng, logic [ROW_W-1:0] row,
                              logic [COL_W-1:0] col, bit known, depth_res_t res);
        int gap;
        if (!quiet && $urandom_range(0, 6) == 0)
        begin
            gap = $urandom_range(1, 5);
            range_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        range_valid <= 1'b1;
        range_q16   <= rng;
        pixel_row   <= row;
        pixel_col   <= col;
        do
            @(posedge clk);
        while (range_stall);
        depth_q.push_back(known ? res : planar_depth(rng, row, col));
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_DEPTH_SCALE)
            scale_reg = val;
        else
            focal_reg = val;
        @(negedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        range_valid <= 1'b0;
        while (depth_q.size() != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    function automatic logic [RANGE_W-1:0] rand_range();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($urandom_range(0, 32'h000F_FFFF));
            2: return -32'($urandom_range(0, 32'h000F_FFFF));
            default: return 32'($urandom_range(0, 32'h0000_3FFF));
        endcase
    endfunction

    initial
    begin
        dir_row_t   dir_tab[$];
        depth_res_t z;
        dir_row_t   d;
        int         phase;
        int         k;
        logic [CFG_W-1:0] sc[5];
        logic [CFG_W-1:0] fc[5];
        err_cnt     = 0;
        quiet       = 1'b0;
        hold_long   = 1'b0;
        scale_reg   = DEPTH_SCALE_RST;
        focal_reg   = FOCAL_RST;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        range_valid = 1'b0;
        range_q16   = '0;
        pixel_row   = '0;
        pixel_col   = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        z = '0;
        // zero range, most negative, negative, and overflow are easy to read off
        dir_tab = '{
            '{32'h0000_0000, 9'd0,   10'd0,   1'b1, '{16'd0, 1'b0}},
            '{32'h8000_0000, 9'd240, 10'd320, 1'b1, '{16'd0, 1'b1}},
            '{32'hFFFF_FFFF, 9'd479, 10'd639, 1'b1, '{16'd0, 1'b1}},
            '{32'h7FFF_FFFF, 9'd240, 10'd320, 1'b1, '{16'hFFFF, 1'b1}},
            '{32'h7FFF_FFFF, 9'd0,   10'd0,   1'b1, '{16'hFFFF, 1'b1}},
            '{32'h0001_0000, 9'd240, 10'd320, 1'b0, z},
            '{32'h0001_0000, 9'd0,   10'd0,   1'b0, z},
            '{32'h0000_0001, 9'd479, 10'd639, 1'b0, z},
            '{32'h0000_0147, 9'd239, 10'd319, 1'b0, z},
            '{32'h0010_0000, 9'd511, 10'd1023, 1'b0, z},
            '{32'h0000_8000, 9'd100, 10'd700, 1'b0, z},
            '{32'h5555_5555, 9'd170, 10'd341, 1'b0, z},
            '{32'h0000_AAAA, 9'd341, 10'd682, 1'b0, z}
        };
        foreach (dir_tab[i])
        begin
            d = dir_tab[i];
            send_range(d.rng, d.row, d.col, d.known, d.res);
        end
        drain();

        sc = '{16'd1, 16'd65535, 16'd5000, 16'd0, 16'd50};
        fc = '{16'd1, 16'd65535, 16'd7690, 16'd0, 16'd480};
        for (phase = 0; phase < 5; phase++)
        begin
            write_reg(CFG_DEPTH_SCALE, sc[phase]);
            write_reg(CFG_FOCAL, fc[phase]);
            cfg_valid <= 1'b0;
            if (phase == 2)
                hold_long = 1'b1;
            if (phase == 4)
                quiet = 1'b1;
            for (k = 0; k < N_RANDOM / 5; k++)
                send_range(rand_range(), 9'($urandom_range(0, 511)),
                           10'($urandom_range(0, 1023)), 1'b0, z);
            drain();
        end

        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
